FILE: src/od_line_duty_mode_classifier_assert.svh
// Assertion macros shared by the line duty classifier RTL.
`ifndef OD_LINE_DUTY_MODE_CLASSIFIER_ASSERT_SVH
`define OD_LINE_DUTY_MODE_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ODL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ODL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/od_ldmc_pkg.sv
// Package of the line duty classifier: codes, widths and shared types.
package od_ldmc_pkg;

  localparam int CFG_ADDR_W   = 5;
  localparam int CFG_DATA_W   = 32;
  localparam int TICK_W       = 8;
  localparam int CYCLE_W      = 9;
  localparam int DUTY_W       = 7;
  localparam int BTN_W        = 16;
  localparam int WAIT_W       = 5;
  localparam int DIVIDEND_W   = 15;
  localparam int DIV_CNT_W    = 3;

  localparam logic [WAIT_W-1:0] RELEASE_WAIT   = 5'd20;
  localparam logic [7:0]        REPEAT_NEEDED  = 8'd3;
  localparam logic [7:0]        REPEAT_MAX     = 8'd255;
  localparam logic [TICK_W-1:0] TICK_MAX       = 8'd255;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_STANDBY    = 3'd1,
    EV_SETUP      = 3'd2,
    EV_MASTER     = 3'd3,
    EV_FIND_FIRST = 3'd4,
    EV_UNKNOWN    = 3'd5
  } tick_mode_t;

  typedef enum logic [1:0] {
    LM_UNKNOWN    = 2'd0,
    LM_SETUP      = 2'd1,
    LM_FIND_FIRST = 2'd2
  } latched_mode_t;

  typedef enum logic [1:0] {
    CM_STANDBY    = 2'd0,
    CM_SETUP      = 2'd1,
    CM_FIND_FIRST = 2'd2,
    CM_UNKNOWN    = 2'd3
  } current_mode_t;

  typedef enum logic [2:0] {
    CFG_PERIOD     = 3'd0,
    CFG_VALID_CYC  = 3'd1,
    CFG_FF_LOW     = 3'd2,
    CFG_FF_HIGH    = 3'd3,
    CFG_SETUP_LOW  = 3'd4,
    CFG_SETUP_HIGH = 3'd5,
    CFG_STBY_MAX   = 3'd6,
    CFG_BTN_HOLD   = 3'd7
  } cfg_idx_t;

  // Divider handshake between the sequencer and the divide unit.
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [CYCLE_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DUTY_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: src/od_ldmc_ifs.sv
// Valid/ready stream interfaces for the tick input and the result output.
interface od_ldmc_in_if;
  logic valid;
  logic ready;
  logic line_level;
  logic button_level;
  logic restart_search;

  modport source (output valid, output line_level, output button_level,
                  output restart_search, input ready);
  modport sink (input valid, input line_level, input button_level,
                input restart_search, output ready);
endinterface

interface od_ldmc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] tick_mode;
  logic       master_request;
  logic       id_request;
  logic [1:0] latched_mode;
  logic [1:0] current_mode;

  modport source (output valid, output tick_mode, output master_request,
                  output id_request, output latched_mode, output current_mode,
                  input ready);
  modport sink (input valid, input tick_mode, input master_request,
                input id_request, input latched_mode, input current_mode,
                output ready);
endinterface

FILE: src/od_ldmc_div.sv
// Serial restoring divider: one compare and subtract per cycle, duty quotient.
module od_ldmc_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  od_ldmc_pkg::div_req_t req,
  output od_ldmc_pkg::div_rsp_t rsp
);

  localparam int DW = od_ldmc_pkg::DIVIDEND_W;
  localparam int QW = od_ldmc_pkg::DUTY_W;
  localparam int CW = od_ldmc_pkg::CYCLE_W;

  logic [DW-1:0]                    rem_r;
  logic [DW-1:0]                    dsr_r;
  logic [QW-1:0]                    quo_r;
  logic [od_ldmc_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                             busy_r;
  logic                             done_r;
  logic                             ge;

  assign ge = (rem_r >= dsr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= od_ldmc_pkg::DIV_CNT_W'(QW - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Divisor starts aligned to the top quotient bit and walks down.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend;
      dsr_r <= {req.divisor, {(DW-CW){1'b0}}};
      quo_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsr_r;
      end
      dsr_r <= dsr_r >> 1;
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

FILE: src/od_line_duty_mode_classifier.sv
// Top level of the open-drain line duty classifier with button master request.
// One transfer in per 1 ms tick, one result out per tick. A tick holds the input
// while it passes through the states in order: the transfer, which updates the line
// and button counters, S_START to launch the divide, S_WAIT in the serial divider
// (seven compare and subtract steps and its done flag) that forms duty =
// high*100/(high+low), and S_DONE to classify, qualify the mode and load the output
// register. The result becomes valid and the input ready again in the same cycle, so
// the next tick may enter while the result waits to be taken; a result not taken by
// the time the next one is due holds the sequencer in S_DONE before its load.
// Registers sit on the APB port at byte address 4*i, pready is always high.
`include "od_line_duty_mode_classifier_assert.svh"

module od_line_duty_mode_classifier (
  input  logic                                   clk,
  input  logic                                   rst_n,
  od_ldmc_in_if.sink                             in_if,
  od_ldmc_out_if.source                          out_if,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [od_ldmc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [od_ldmc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [od_ldmc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                   pready
);

  localparam int TW = od_ldmc_pkg::TICK_W;
  localparam int CW = od_ldmc_pkg::CYCLE_W;
  localparam int QW = od_ldmc_pkg::DUTY_W;
  localparam int BW = od_ldmc_pkg::BTN_W;
  localparam int WW = od_ldmc_pkg::WAIT_W;
  localparam int DATA_W = od_ldmc_pkg::CFG_DATA_W;

  localparam logic [1:0] PH_LOW  = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_NONE = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_WAIT  = 5'b00100,
    S_DONE  = 5'b01000,
    S_SPARE = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    K_NONE   = 2'd0,
    K_MASTER = 2'd1,
    K_CLS    = 2'd2
  } ev_kind_t;

  // Configuration registers
  logic [TW-1:0] cfg_period_r;
  logic [CW-1:0] cfg_valid_cyc_r;
  logic [QW-1:0] cfg_ff_low_r;
  logic [QW-1:0] cfg_ff_high_r;
  logic [QW-1:0] cfg_setup_low_r;
  logic [QW-1:0] cfg_setup_high_r;
  logic [QW-1:0] cfg_stby_max_r;
  logic [BW-1:0] cfg_btn_hold_r;

  logic                   cfg_wr;
  od_ldmc_pkg::cfg_idx_t  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = od_ldmc_pkg::cfg_idx_t'(paddr[od_ldmc_pkg::CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_period_r     <= 8'd60;
      cfg_valid_cyc_r  <= 9'd54;
      cfg_ff_low_r     <= 7'd65;
      cfg_ff_high_r    <= 7'd85;
      cfg_setup_low_r  <= 7'd40;
      cfg_setup_high_r <= 7'd60;
      cfg_stby_max_r   <= 7'd5;
      cfg_btn_hold_r   <= 16'd1500;
    end else if (cfg_wr) begin
      case (cfg_idx)
        od_ldmc_pkg::CFG_PERIOD:     cfg_period_r     <= pwdata[TW-1:0];
        od_ldmc_pkg::CFG_VALID_CYC:  cfg_valid_cyc_r  <= pwdata[CW-1:0];
        od_ldmc_pkg::CFG_FF_LOW:     cfg_ff_low_r     <= pwdata[QW-1:0];
        od_ldmc_pkg::CFG_FF_HIGH:    cfg_ff_high_r    <= pwdata[QW-1:0];
        od_ldmc_pkg::CFG_SETUP_LOW:  cfg_setup_low_r  <= pwdata[QW-1:0];
        od_ldmc_pkg::CFG_SETUP_HIGH: cfg_setup_high_r <= pwdata[QW-1:0];
        od_ldmc_pkg::CFG_STBY_MAX:   cfg_stby_max_r   <= pwdata[QW-1:0];
        od_ldmc_pkg::CFG_BTN_HOLD:   cfg_btn_hold_r   <= pwdata[BW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      od_ldmc_pkg::CFG_PERIOD:     prdata = DATA_W'(cfg_period_r);
      od_ldmc_pkg::CFG_VALID_CYC:  prdata = DATA_W'(cfg_valid_cyc_r);
      od_ldmc_pkg::CFG_FF_LOW:     prdata = DATA_W'(cfg_ff_low_r);
      od_ldmc_pkg::CFG_FF_HIGH:    prdata = DATA_W'(cfg_ff_high_r);
      od_ldmc_pkg::CFG_SETUP_LOW:  prdata = DATA_W'(cfg_setup_low_r);
      od_ldmc_pkg::CFG_SETUP_HIGH: prdata = DATA_W'(cfg_setup_high_r);
      od_ldmc_pkg::CFG_STBY_MAX:   prdata = DATA_W'(cfg_stby_max_r);
      od_ldmc_pkg::CFG_BTN_HOLD:   prdata = DATA_W'(cfg_btn_hold_r);
      default:                     prdata = '0;
    endcase
  end

  // Tick state
  state_t        state_r, state_nxt;
  ev_kind_t      kind_r, kind_nxt;
  logic [1:0]    line_phase_r, line_phase_nxt;
  logic [TW-1:0] tick_count_r, tick_count_nxt;
  logic [TW-1:0] high_ticks_r, high_ticks_nxt;
  logic [TW-1:0] low_ticks_r, low_ticks_nxt;
  logic [BW-1:0] button_ticks_r, button_ticks_nxt;
  logic [WW-1:0] release_wait_r, release_wait_nxt;
  logic [2:0]    last_mode_r, last_mode_nxt;
  logic [7:0]    mode_repeats_r, mode_repeats_nxt;
  logic [1:0]    qual_mode_r, qual_mode_nxt;

  // Output register
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] o_tick_mode_r, o_tick_mode_nxt;
  logic       o_master_r, o_master_nxt;
  logic       o_id_req_r, o_id_req_nxt;
  logic [1:0] o_latched_r, o_latched_nxt;
  logic [1:0] o_current_r, o_current_nxt;

  od_ldmc_pkg::div_req_t div_req;
  od_ldmc_pkg::div_rsp_t div_rsp;

  logic                                  in_acc;
  logic [CW-1:0]                         cycle;
  logic [od_ldmc_pkg::DIVIDEND_W-1:0]    high_x100;
  od_ldmc_pkg::tick_mode_t               cls;
  logic [1:0]                            cur;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid & in_if.ready;

  assign cycle     = CW'(high_ticks_r) + CW'(low_ticks_r);
  assign high_x100 = (od_ldmc_pkg::DIVIDEND_W'(high_ticks_r) << 6)
                   + (od_ldmc_pkg::DIVIDEND_W'(high_ticks_r) << 5)
                   + (od_ldmc_pkg::DIVIDEND_W'(high_ticks_r) << 2);

  assign div_req.start    = (state_r == S_START);
  assign div_req.dividend = high_x100;
  assign div_req.divisor  = cycle;

  od_ldmc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Classify from the held counts and the divider quotient.
  always_comb begin
    if (cycle < cfg_valid_cyc_r || cycle == '0) begin
      cls = od_ldmc_pkg::EV_UNKNOWN;
    end else if (div_rsp.quotient >= cfg_ff_low_r && div_rsp.quotient <= cfg_ff_high_r) begin
      cls = od_ldmc_pkg::EV_FIND_FIRST;
    end else if (div_rsp.quotient >= cfg_setup_low_r &&
                 div_rsp.quotient <= cfg_setup_high_r) begin
      cls = od_ldmc_pkg::EV_SETUP;
    end else if (div_rsp.quotient < cfg_stby_max_r) begin
      cls = od_ldmc_pkg::EV_STANDBY;
    end else begin
      cls = od_ldmc_pkg::EV_UNKNOWN;
    end
    case (cls)
      od_ldmc_pkg::EV_STANDBY:    cur = od_ldmc_pkg::CM_STANDBY;
      od_ldmc_pkg::EV_SETUP:      cur = od_ldmc_pkg::CM_SETUP;
      od_ldmc_pkg::EV_FIND_FIRST: cur = od_ldmc_pkg::CM_FIND_FIRST;
      default:                    cur = od_ldmc_pkg::CM_UNKNOWN;
    endcase
  end

  always_comb begin
    logic                    mst;
    logic [2:0]              ev;
    logic                    id_req;
    state_nxt        = state_r;
    kind_nxt         = kind_r;
    line_phase_nxt   = line_phase_r;
    tick_count_nxt   = tick_count_r;
    high_ticks_nxt   = high_ticks_r;
    low_ticks_nxt    = low_ticks_r;
    button_ticks_nxt = button_ticks_r;
    release_wait_nxt = release_wait_r;
    last_mode_nxt    = last_mode_r;
    mode_repeats_nxt = mode_repeats_r;
    qual_mode_nxt    = qual_mode_r;
    out_valid_nxt    = out_valid_r & ~out_if.ready;
    o_tick_mode_nxt  = o_tick_mode_r;
    o_master_nxt     = o_master_r;
    o_id_req_nxt     = o_id_req_r;
    o_latched_nxt    = o_latched_r;
    o_current_nxt    = o_current_r;
    mst              = 1'b0;
    ev               = od_ldmc_pkg::EV_NONE;
    id_req           = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_START;
          kind_nxt  = K_NONE;
          if (in_if.restart_search) begin
            qual_mode_nxt = od_ldmc_pkg::LM_UNKNOWN;
          end
          if (tick_count_nxt != od_ldmc_pkg::TICK_MAX) begin
            tick_count_nxt = tick_count_nxt + 1'b1;
          end
          // Button: count while pressed and not in the release wait.
          if (!in_if.button_level) begin
            if (release_wait_nxt == '0) begin
              button_ticks_nxt = button_ticks_nxt + 1'b1;
              if (button_ticks_nxt == cfg_btn_hold_r) begin
                release_wait_nxt = od_ldmc_pkg::RELEASE_WAIT;
                mst              = 1'b1;
                kind_nxt         = K_MASTER;
              end
            end
          end else begin
            if (release_wait_nxt != '0) begin
              release_wait_nxt = release_wait_nxt - 1'b1;
            end
            button_ticks_nxt = '0;
          end
          // Line: skip sampling on a master request tick.
          if (!mst) begin
            if (!in_if.line_level) begin
              if (line_phase_nxt != PH_LOW) begin
                high_ticks_nxt = tick_count_nxt;
                tick_count_nxt = '0;
                line_phase_nxt = PH_LOW;
              end
              if (tick_count_nxt == cfg_period_r) begin
                high_ticks_nxt = '0;
                low_ticks_nxt  = cfg_period_r;
                tick_count_nxt = '0;
                kind_nxt       = K_CLS;
              end
            end else begin
              if (line_phase_nxt != PH_HIGH) begin
                low_ticks_nxt  = tick_count_nxt;
                tick_count_nxt = '0;
                line_phase_nxt = PH_HIGH;
                kind_nxt       = K_CLS;
              end else if (tick_count_nxt == cfg_period_r) begin
                high_ticks_nxt = cfg_period_r;
                low_ticks_nxt  = '0;
                tick_count_nxt = '0;
              end
            end
          end
        end
      end
      S_START: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          state_nxt = S_IDLE;
          case (kind_r)
            K_MASTER: ev = od_ldmc_pkg::EV_MASTER;
            K_CLS:    ev = cls;
            default:  ev = od_ldmc_pkg::EV_NONE;
          endcase
          // Qualify: a mode must repeat before it latches.
          if (ev != od_ldmc_pkg::EV_NONE) begin
            if (last_mode_r != ev) begin
              last_mode_nxt    = ev;
              mode_repeats_nxt = '0;
            end
            if (ev == od_ldmc_pkg::EV_MASTER) begin
              qual_mode_nxt = od_ldmc_pkg::LM_UNKNOWN;
            end else begin
              if (mode_repeats_nxt != od_ldmc_pkg::REPEAT_MAX) begin
                mode_repeats_nxt = mode_repeats_nxt + 1'b1;
              end
              if (mode_repeats_nxt >= od_ldmc_pkg::REPEAT_NEEDED) begin
                if (ev == od_ldmc_pkg::EV_SETUP) begin
                  qual_mode_nxt = od_ldmc_pkg::LM_SETUP;
                  id_req        = 1'b1;
                end else if (ev == od_ldmc_pkg::EV_FIND_FIRST) begin
                  qual_mode_nxt = od_ldmc_pkg::LM_FIND_FIRST;
                end
              end
            end
          end
          out_valid_nxt   = 1'b1;
          o_tick_mode_nxt = ev;
          o_master_nxt    = (kind_r == K_MASTER);
          o_id_req_nxt    = id_req;
          o_latched_nxt   = qual_mode_nxt;
          o_current_nxt   = cur;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      kind_r         <= K_NONE;
      line_phase_r   <= PH_NONE;
      tick_count_r   <= '0;
      high_ticks_r   <= '0;
      low_ticks_r    <= '0;
      button_ticks_r <= '0;
      release_wait_r <= '0;
      last_mode_r    <= od_ldmc_pkg::EV_NONE;
      mode_repeats_r <= '0;
      qual_mode_r    <= od_ldmc_pkg::LM_UNKNOWN;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      kind_r         <= kind_nxt;
      line_phase_r   <= line_phase_nxt;
      tick_count_r   <= tick_count_nxt;
      high_ticks_r   <= high_ticks_nxt;
      low_ticks_r    <= low_ticks_nxt;
      button_ticks_r <= button_ticks_nxt;
      release_wait_r <= release_wait_nxt;
      last_mode_r    <= last_mode_nxt;
      mode_repeats_r <= mode_repeats_nxt;
      qual_mode_r    <= qual_mode_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_tick_mode_r <= o_tick_mode_nxt;
    o_master_r    <= o_master_nxt;
    o_id_req_r    <= o_id_req_nxt;
    o_latched_r   <= o_latched_nxt;
    o_current_r   <= o_current_nxt;
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.tick_mode      = o_tick_mode_r;
  assign out_if.master_request = o_master_r;
  assign out_if.id_request     = o_id_req_r;
  assign out_if.latched_mode   = o_latched_r;
  assign out_if.current_mode   = o_current_r;

  `ODL_ASSERT_IMP(a_master_flag, out_if.valid,
    out_if.master_request == (out_if.tick_mode == od_ldmc_pkg::EV_MASTER),
    "master_request disagrees with tick_mode")
  `ODL_ASSERT_IMP(a_id_setup, out_if.valid && out_if.id_request,
    out_if.tick_mode == od_ldmc_pkg::EV_SETUP && out_if.latched_mode == od_ldmc_pkg::LM_SETUP,
    "id_request without a latched host setup event")
  `ODL_ASSERT_IMP(a_ff_live, out_if.valid && out_if.tick_mode == od_ldmc_pkg::EV_FIND_FIRST,
    out_if.current_mode == od_ldmc_pkg::CM_FIND_FIRST,
    "find-first event but live mode differs")
  `ODL_ASSERT_NXT(a_busy_after_in, in_if.valid && in_if.ready, !in_if.ready,
    "input ready right after a transfer in")

endmodule
